// File: src/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg: shared types and constants for the min/max normalizer
// Beat formats, configuration register codes, sequencer states and the
// sizes of the sample store and the serial divider.
// ----------------------------------------------------------------------------
package mmn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = 12;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int DIV_STEPS   = SAMPLE_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_LOW  = 1'b0,
    REG_OUT_HIGH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_e;

  typedef struct packed {
    logic                          func;
    logic                          first;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]              index;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          error;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic                   start;
    logic [PROD_W-1:0]      dividend;
    logic [SAMPLE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/mmn_div.sv
// ----------------------------------------------------------------------------
// mmn_div: serial unsigned divider
// Restoring division, one quotient bit per cycle. The caller guarantees the
// upper half of the dividend is below the divisor, so the quotient fits in
// SAMPLE_BITS and only DIV_STEPS steps are needed.
// ----------------------------------------------------------------------------
module mmn_div
  import mmn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [SAMPLE_BITS-1:0] dvs_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   run_q;
  logic                   done_q;
  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[SAMPLE_BITS-1]};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? SAMPLE_BITS'(trial - {1'b0, dvs_q}) : trial[SAMPLE_BITS-1:0];
    quo_d = {quo_q[SAMPLE_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[PROD_W-1:SAMPLE_BITS];
      quo_q <= req_i.dividend[SAMPLE_BITS-1:0];
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: src/min_max_normalizer_top.sv
// ----------------------------------------------------------------------------
// min_max_normalizer_top: height map store with min-max rescaling
// Loads signed samples into a 4096-entry store while tracking the running
// extremes; reads return an entry mapped onto [out_low, out_high].
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. Every item gives exactly one result beat on result_o, marked
// by result_valid_o for one cycle; the receiver cannot stall it, so sample
// it whenever the strobe is high. For loads the result shows the cycle
// after acceptance and busy never rises, so loads can be issued back to
// back. Reads that miss (index not loaded) also show their result the
// cycle after acceptance. For reads of a flat map (max == min, returns
// out_low), busy is high for the one cycle in which the flat check runs,
// and the result shows the cycle after that. Any other read passes
// through one store read, one multiply, one divider launch, 16 steps of
// the bit-serial divider, then the result register. The store has no
// reset and no clearing pass; only loaded entries ever reach a result.
// Write out_low/out_high only while busy is low and no result is pending;
// the config port is always ready.
// ----------------------------------------------------------------------------
module min_max_normalizer_top
  import mmn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               req_i,
  // result channel
  output logic                   result_valid_o,
  output out_item_t              result_o,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i
);

  // --- state -----------------------------------------------------------------
  state_e                        state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] out_low_q, out_high_q;
  logic [CNT_W-1:0]              count_q;
  logic signed [SAMPLE_BITS-1:0] min_q, max_q;

  logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;

  logic [PROD_W-1:0]             prod_q;
  logic                          neg_q;

  logic                          res_valid_q;
  out_item_t                     res_q;

  div_req_t                      div_req;
  div_rsp_t                      div_rsp;

  // --- accept / load decode -------------------------------------------------
  logic                          accept;
  logic                          is_load;
  logic                          is_read;
  logic [CNT_W-1:0]              eff_count;
  logic                          load_ovf;
  logic                          load_we;
  logic                          read_miss;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign is_load = accept && (req_i.func == FUNC_LOAD);
  assign is_read = accept && (req_i.func == FUNC_READ);

  // a first-marked load restarts before the store, so it never overflows
  assign eff_count = req_i.first ? '0 : count_q;
  assign load_ovf  = (eff_count >= CNT_W'(STORE_DEPTH));
  assign load_we   = is_load && !load_ovf;
  assign read_miss = (32'(req_i.index) >= 32'(count_q));

  // --- read-side arithmetic ---------------------------------------------------
  logic signed [SAMPLE_BITS:0]   diff_s, span_s, range_s;
  logic [SAMPLE_BITS-1:0]        diff_u, span_mag, range_u;
  logic                          span_neg;
  logic                          flat;
  logic [SAMPLE_BITS-1:0]        q_signed;

  always_comb begin
    diff_s   = (SAMPLE_BITS+1)'(rdata_q) - (SAMPLE_BITS+1)'(min_q);
    span_s   = (SAMPLE_BITS+1)'(out_high_q) - (SAMPLE_BITS+1)'(out_low_q);
    range_s  = (SAMPLE_BITS+1)'(max_q) - (SAMPLE_BITS+1)'(min_q);
    diff_u   = diff_s[SAMPLE_BITS-1:0];      // stored sample >= min
    span_neg = span_s[SAMPLE_BITS];
    span_mag = span_neg ? SAMPLE_BITS'(-span_s) : span_s[SAMPLE_BITS-1:0];
    range_u  = range_s[SAMPLE_BITS-1:0];     // max >= min
    flat     = (max_q == min_q);
    q_signed = neg_q ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
  end

  // --- sequencer ----------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (is_read && !read_miss) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = flat ? ST_IDLE : ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign div_req.dividend = prod_q;
  assign div_req.divisor  = range_u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --- configuration ------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_low_q  <= '0;
      out_high_q <= SAMPLE_BITS'(255);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OUT_LOW:  out_low_q  <= cfg_data_i;
        REG_OUT_HIGH: out_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --- count and running extremes -------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
    end else if (load_we) begin
      count_q <= eff_count + 1'b1;
      if (eff_count == '0) begin
        min_q <= req_i.sample;
        max_q <= req_i.sample;
      end else begin
        if (req_i.sample < min_q) min_q <= req_i.sample;
        if (req_i.sample > max_q) max_q <= req_i.sample;
      end
    end
  end

  // --- sample store, registered read ------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[eff_count[ADDR_W-1:0]] <= req_i.sample;
    end
    if (is_read) begin
      rdata_q <= mem[req_i.index[ADDR_W-1:0]];
    end
  end

  // --- product register ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= diff_u * span_mag;
      neg_q  <= span_neg;
    end
  end

  mmn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --- result beat ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= is_load || (is_read && read_miss) ||
                     (state_q == ST_MUL && flat) ||
                     (state_q == ST_DIV_WAIT && div_rsp.done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      res_q.value <= '0;
      res_q.error <= load_ovf;
    end else if (is_read && read_miss) begin
      res_q.value <= '0;
      res_q.error <= 1'b1;
    end else if (state_q == ST_MUL && flat) begin
      res_q.value <= out_low_q;
      res_q.error <= 1'b0;
    end else if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      res_q.value <= out_low_q + q_signed;
      res_q.error <= 1'b0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// File: sim/mmn_checker.sv
// ----------------------------------------------------------------------------
// mmn_checker: scoreboard for the min/max normalizer
// Snoops the command, result and config channels, keeps its own copy of the
// height map and output range, and checks every result beat in order.
// ----------------------------------------------------------------------------
module mmn_checker
  import mmn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  in_item_t               req_i,
  input  logic                   result_valid_i,
  input  out_item_t              result_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  logic signed [SAMPLE_BITS-1:0] height_map [STORE_DEPTH];
  logic [CNT_W-1:0]              map_count;
  logic signed [SAMPLE_BITS-1:0] map_min;
  logic signed [SAMPLE_BITS-1:0] map_max;
  logic signed [SAMPLE_BITS-1:0] range_low;
  logic signed [SAMPLE_BITS-1:0] range_high;
  out_item_t                     pending_beats [$];

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count_o++;
  endtask

  // Applies one command to the shadow map and returns the beat it should give.
  function automatic out_item_t normalize_item(in_item_t it);
    out_item_t                     r;
    logic signed [SAMPLE_BITS-1:0] s;
    longint                        span;
    longint                        diff;
    longint                        scaled;
    r = '0;
    s = it.sample;
    if (it.func == FUNC_LOAD) begin
      if (it.first) map_count = '0;
      if (map_count >= STORE_DEPTH) begin
        r.error = 1'b1;           // store full, sample dropped
      end else begin
        height_map[map_count[ADDR_W-1:0]] = s;
        if (map_count == '0) begin
          map_min = s;
          map_max = s;
        end else begin
          if (s < map_min) map_min = s;
          if (s > map_max) map_max = s;
        end
        map_count = map_count + 1'b1;
      end
    end else if (it.index >= map_count) begin
      r.error = 1'b1;
    end else begin
      span = longint'(map_max) - longint'(map_min);
      if (span <= 0) begin
        r.value = range_low;      // flat map
      end else begin
        diff   = longint'(height_map[it.index]) - longint'(map_min);
        scaled = longint'(range_low)
               + diff * (longint'(range_high) - longint'(range_low)) / span;
        r.value = scaled[SAMPLE_BITS-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      map_count    = '0;
      map_min      = '0;
      map_max      = '0;
      range_low    = '0;
      range_high   = 16'sd255;
      fail_count_o = 0;
      pending_beats.delete();
    end else begin
      // a result is registered after its command is accepted, so pop first
      if (result_valid_i) begin
        if (pending_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat value=%0d error=%0b",
                                    $signed(result_i.value), result_i.error));
        end else begin
          want = pending_beats.pop_front();
          if (result_i.value !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d",
                                      $signed(result_i.value), $signed(want.value)));
          if (result_i.error !== want.error)
            report_mismatch($sformatf("error %0b, expected %0b",
                                      result_i.error, want.error));
        end
      end
      if (start_i && !busy_i) pending_beats.push_back(normalize_item(req_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_OUT_LOW:  range_low  = cfg_data_i;
          REG_OUT_HIGH: range_high = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = pending_beats.size();
  end

endmodule

// File: sim/tb_min_max_normalizer_top.sv
// ----------------------------------------------------------------------------
// tb_min_max_normalizer_top: stimulus and verdict for the min/max normalizer
// Directed corner beats, a full-store pass with overflow, then random load
// and read sequences under several output ranges; mmn_checker scores beats.
// ----------------------------------------------------------------------------
module tb_min_max_normalizer_top;
  import mmn_pkg::*;

  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400_000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  in_item_t               req;
  logic                   result_valid;
  out_item_t              result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SAMPLE_BITS-1:0] cfg_data;
  int                     fail_count;
  int                     pending;

  int   cycles = 0;
  int   items_sent = 0;
  int   loaded = 0;      // stimulus-side fill level, used to aim read indices
  logic steady = 1'b0;   // no sender gaps while set

  always #1 clk_i = ~clk_i;

  min_max_normalizer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  mmn_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one command beat and holds it until taken. start stays high
  // when no gap follows, so the next call simply replaces the payload.
  task automatic send_item(func_e fn, logic first, logic [SAMPLE_BITS-1:0] smp,
                           logic [IDX_W-1:0] idx);
    in_item_t it;
    int       gap;
    it.func   = fn;
    it.first  = first;
    it.sample = smp;
    it.index  = idx;
    start <= 1'b1;
    req   <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load(logic first, logic [SAMPLE_BITS-1:0] smp);
    if (first) loaded = 0;
    if (loaded < STORE_DEPTH) loaded++;
    send_item(FUNC_LOAD, first, smp, IDX_W'($urandom));
  endtask

  task automatic read(logic [IDX_W-1:0] idx);
    send_item(FUNC_READ, 1'($urandom), SAMPLE_BITS'($urandom), idx);
  endtask

  // Read aimed mostly at loaded entries, sometimes past the fill level.
  task automatic read_some();
    if (loaded > 0 && $urandom_range(0, 9) < 8)
      read(IDX_W'($urandom_range(0, loaded - 1)));
    else if (loaded < STORE_DEPTH)
      read(IDX_W'($urandom_range(loaded, STORE_DEPTH - 1)));
    else
      read(IDX_W'($urandom));
  endtask

  // Stop sending and wait for every outstanding beat. The pending count is
  // sampled on the falling edge so it never races the checker.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called right after drain_results, while the block is idle.
  task automatic set_out_range(logic [SAMPLE_BITS-1:0] lo, logic [SAMPLE_BITS-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_OUT_LOW;
    cfg_data  <= lo;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= REG_OUT_HIGH;
    cfg_data  <= hi;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int mode,
                                                         logic [SAMPLE_BITS-1:0] base);
    case (mode)
      0:       return SAMPLE_BITS'($urandom);
      1:       return base + SAMPLE_BITS'($urandom_range(0, 15));  // narrow spread
      2:       return base;                                        // flat map
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return SAMPLE_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  initial begin
    int                     mode;
    int                     n_loads;
    int                     n_reads;
    logic [SAMPLE_BITS-1:0] base;

    rst_ni    = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OUT_LOW;
    cfg_data  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed corners, reset range 0..255 ----
    read(12'd0);                 // nothing loaded yet
    load(1'b0, 16'sd100);        // first entry after reset, no restart flag
    read(12'd0);                 // single entry: flat map gives out_low
    load(1'b0, 16'h8000);
    load(1'b0, 16'h7fff);
    read(12'd0);
    read(12'd1);
    read(12'd2);
    read(12'd3);                 // one past the fill level
    read(12'hfff);
    load(1'b1, 16'sd5);          // restart
    read(12'd1);                 // now beyond the count
    read(12'd0);

    // descending scale at the widest extremes
    drain_results();
    set_out_range(16'h7fff, 16'h8000);
    load(1'b1, 16'h8000);
    load(1'b0, 16'h7fff);
    load(1'b0, 16'h0000);
    read(12'd0);
    read(12'd1);
    read(12'd2);

    // widest ascending scale: largest products the divider sees
    drain_results();
    set_out_range(16'h8000, 16'h7fff);
    read(12'd0);
    read(12'd1);
    read(12'd2);

    // ---- fill the whole store, then overflow it ----
    drain_results();
    set_out_range(16'h0000, 16'h00ff);
    steady = 1'b1;
    load(1'b1, SAMPLE_BITS'($urandom));
    repeat (STORE_DEPTH - 1) load(1'b0, SAMPLE_BITS'($urandom));
    load(1'b0, SAMPLE_BITS'($urandom));   // dropped, flagged
    load(1'b0, 16'h7fff);                 // dropped, must not move the max
    steady = 1'b0;
    read(12'hfff);
    read(12'h000);
    read(IDX_W'($urandom));
    load(1'b1, 16'h1234);                 // restart on a full store is no overflow
    read(12'd1);
    read(12'd0);

    // ---- random load/read sequences ----
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      mode   = $urandom_range(0, 3);
      base   = SAMPLE_BITS'($urandom);
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        drain_results();
        case ($urandom_range(0, 4))
          0:       set_out_range(16'h0000, 16'h00ff);
          1:       set_out_range(16'h8000, 16'h7fff);
          2:       set_out_range(16'h7fff, 16'h8000);
          3:       begin
            base = SAMPLE_BITS'($urandom);
            set_out_range(base, base);
          end
          default: set_out_range(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        drain_results();         // sender holds off until all beats are back
      end

      n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 8);
      for (int i = 0; i < n_loads; i++) begin
        load(i == 0 && $urandom_range(0, 4) != 0, pick_sample(mode, base));
        if ($urandom_range(0, 9) == 0) read_some();   // read mid-sequence
      end

      n_reads = $urandom_range(1, 10);
      repeat (n_reads) read_some();

      // noise: anything the fields allow
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) load(1'($urandom), SAMPLE_BITS'($urandom));
        else read(IDX_W'($urandom));
      end
    end

    drain_results();
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
